// ===== sv/mks_pkg.sv =====
// Package for the keypad scanner: types, codes and the fixed key table.
package mks_pkg;

   localparam int unsigned NumKeys  = 16;
   localparam int unsigned KeyWidth = 4;
   localparam int unsigned ColWidth = 4;
   localparam int unsigned RowWidth = 4;
   localparam int unsigned CntWidth = 16;

   localparam logic [CntWidth-1:0] LockoutReset = 16'd50000;
   localparam logic [ColWidth-1:0] ColAllHigh   = 4'hF;

   // Row patterns, a zero bit marks the driven row.
   localparam logic [RowWidth-1:0] RowsIdle = 4'h0;
   localparam logic [RowWidth-1:0] RowsZero = 4'd14;
   localparam logic [RowWidth-1:0] RowsOne  = 4'd13;
   localparam logic [RowWidth-1:0] RowsTwo  = 4'd11;
   localparam logic [RowWidth-1:0] RowsThree = 4'd7;

   typedef enum logic [2:0] {
      PHASE_IDLE  = 3'd0,
      PHASE_ROW0  = 3'd1,
      PHASE_ROW1  = 3'd2,
      PHASE_ROW2  = 3'd3,
      PHASE_ROW3  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_KEY      = 2'd1,
      STATUS_UNKNOWN  = 2'd2,
      STATUS_LOCKOUT  = 2'd3
   } status_type;

   typedef struct packed {
      logic [RowWidth-1:0] row_drive;
      status_type          scan_status;
      logic [KeyWidth-1:0] key_index;
   } result_type;

   // Row and column byte of each key, in key index order.
   localparam logic [7:0] KeyTable [NumKeys] = '{
      8'd231, 8'd190, 8'd189, 8'd187, 8'd222, 8'd221, 8'd219, 8'd238,
      8'd237, 8'd235, 8'd126, 8'd125, 8'd123, 8'd119, 8'd183, 8'd215
   };

endpackage

// ===== sv/mks_step.sv =====
// Next-state and result logic of the keypad scanner for one column sample.
module mks_step (
   input  mks_pkg::phase_type                      phase,
   input  logic [mks_pkg::CntWidth-1:0]            lockout_count,
   input  logic [mks_pkg::CntWidth-1:0]            lockout_scans,
   input  logic [mks_pkg::ColWidth-1:0]            column_sample,
   output mks_pkg::phase_type                      phase_next,
   output logic [mks_pkg::CntWidth-1:0]            lockout_next,
   output mks_pkg::result_type                     result
);
   import mks_pkg::*;

   logic [RowWidth-1:0] rows_now;
   logic [7:0]          code;
   logic                hit;
   logic [KeyWidth-1:0] hit_index;
   logic                any_low;

   assign any_low = (column_sample != ColAllHigh);
   assign code    = {rows_now, column_sample};

   // Parallel compare against every table entry; entries are distinct.
   always_comb begin
      hit       = 1'b0;
      hit_index = '0;
      for (int i = NumKeys - 1; i >= 0; i--) begin
         if (KeyTable[i] == code) begin
            hit       = 1'b1;
            hit_index = KeyWidth'(i);
         end
      end
   end

   always_comb begin
      rows_now           = RowsIdle;
      phase_next         = PHASE_IDLE;
      lockout_next       = lockout_count;
      result.row_drive   = RowsIdle;
      result.scan_status = STATUS_NONE;
      result.key_index   = '0;
      unique case (phase)
         PHASE_ROW0: begin
            rows_now         = RowsZero;
            phase_next       = PHASE_ROW1;
            result.row_drive = RowsOne;
         end
         PHASE_ROW1: begin
            rows_now         = RowsOne;
            phase_next       = PHASE_ROW2;
            result.row_drive = RowsTwo;
         end
         PHASE_ROW2: begin
            rows_now         = RowsTwo;
            phase_next       = PHASE_ROW3;
            result.row_drive = RowsThree;
         end
         PHASE_ROW3: begin
            rows_now         = RowsThree;
            phase_next       = PHASE_IDLE;
            result.row_drive = RowsIdle;
         end
         default: begin
            if (lockout_count != '0) begin
               lockout_next       = lockout_count - 1'b1;
               result.scan_status = STATUS_LOCKOUT;
            end else if (any_low) begin
               lockout_next     = lockout_scans;
               phase_next       = PHASE_ROW0;
               result.row_drive = RowsZero;
            end
         end
      endcase

      // A low column under a driven row ends the scan with a lookup.
      if (phase == PHASE_ROW0 || phase == PHASE_ROW1 ||
          phase == PHASE_ROW2 || phase == PHASE_ROW3) begin
         if (any_low) begin
            phase_next         = PHASE_IDLE;
            result.row_drive   = RowsIdle;
            result.scan_status = hit ? STATUS_KEY : STATUS_UNKNOWN;
            result.key_index   = hit ? hit_index : '0;
         end
      end
   end

endmodule

// ===== sv/matrix_keypad_scanner_unit.sv =====
// Top level of the 4x4 keypad scanner: handshakes, state and result registers.
//
// Usage: each request transaction carries one 4-bit column sample, read from
// the pins under the row drive given by the previous response. Each request
// yields exactly one response transaction with the row drive for the next
// sample, a scan status (nothing, key found, pattern not in table, lockout
// hold) and the key index when a key was found.
// A sample is first held in an input register; the scan logic between that
// register and the response register is a single pass of short logic, with
// the phase and lockout counters updated as the sample moves across.
// A request passes through the input register and then the response register before
// response valid rises; one request can be accepted every cycle as long as the response side keeps up.
// When the receiver raises rsp_stall the response holds, the input register
// fills, and only then is req_stall raised, so no transaction is lost.
// The csr channel writes the lockout length; it is always ready and should be
// used only while no transaction is in flight.
// Synchronous reset empties both registers, returns the scanner to idle, clears
// the lockout count and sets the lockout length to 50000; the row drive is not reset.
module matrix_keypad_scanner_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mks_pkg::ColWidth-1:0]     req_column_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mks_pkg::RowWidth-1:0]     rsp_row_drive,
   output logic [1:0]                       rsp_scan_status,
   output logic [mks_pkg::KeyWidth-1:0]     rsp_key_index,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mks_pkg::CntWidth-1:0]     csr_data
);
   import mks_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [ColWidth-1:0] in_col_ff;
   logic                out_valid_ff, out_valid_in;
   result_type          out_result_ff;
   phase_type           phase_ff, phase_in;
   logic [CntWidth-1:0] lockout_ff, lockout_in;
   logic [CntWidth-1:0] lockout_scans_ff;
   result_type          step_result;
   logic                advance;
   logic                req_take;

   // The held sample moves on when the response register is empty or being
   // taken in this cycle.
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   mks_step u_step (
      .phase         (phase_ff),
      .lockout_count (lockout_ff),
      .lockout_scans (lockout_scans_ff),
      .column_sample (in_col_ff),
      .phase_next    (phase_in),
      .lockout_next  (lockout_in),
      .result        (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         phase_ff         <= PHASE_IDLE;
         lockout_ff       <= '0;
         lockout_scans_ff <= LockoutReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff   <= phase_in;
            lockout_ff <= lockout_in;
         end
         if (csr_valid & csr_ready) begin
            lockout_scans_ff <= csr_data;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_col_ff <= req_column_sample;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_row_drive   = out_result_ff.row_drive;
   assign rsp_scan_status = out_result_ff.scan_status;
   assign rsp_key_index   = out_result_ff.key_index;

endmodule
